// File: rtl/touch_calibrate_gesture_detect_core_macros.svh
// assertion macros shared by the touch gesture detect modules
`ifndef TOUCH_CALIBRATE_GESTURE_DETECT_CORE_MACROS_SVH
`define TOUCH_CALIBRATE_GESTURE_DETECT_CORE_MACROS_SVH

`ifndef SYNTH

// property that must hold in the same cycle as its trigger
`define TCGD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcgd assertion failed");

// property that must hold in the cycle after its trigger
`define TCGD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcgd assertion failed");

`else

`define TCGD_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define TCGD_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/tcgd_pkg.sv
// shared types and constants for the touch gesture detect core
`default_nettype none

package tcgd_pkg;

    // field widths
    localparam int RAW_W     = 12;
    localparam int TIME_W    = 32;
    localparam int PIX_X_W   = 9;
    localparam int PIX_Y_W   = 8;
    localparam int GEST_W    = 3;
    localparam int THR_PIX_W = 9;
    localparam int THR_MS_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAW_X_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_X_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX_PIX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX_MS  = 3'd6;

    // register reset values
    localparam logic [RAW_W-1:0]     RST_RAW_LOW     = 12'd300;
    localparam logic [RAW_W-1:0]     RST_RAW_HIGH    = 12'd3800;
    localparam logic [THR_PIX_W-1:0] RST_SWIPE_MIN   = 9'd40;
    localparam logic [THR_PIX_W-1:0] RST_TAP_MAX_PIX = 9'd20;
    localparam logic [THR_MS_W-1:0]  RST_TAP_MAX_MS  = 16'd450;

    // gesture codes
    localparam logic [GEST_W-1:0] GEST_NONE        = 3'd0;
    localparam logic [GEST_W-1:0] GEST_SWIPE_LEFT  = 3'd1;
    localparam logic [GEST_W-1:0] GEST_SWIPE_RIGHT = 3'd2;
    localparam logic [GEST_W-1:0] GEST_SWIPE_UP    = 3'd3;
    localparam logic [GEST_W-1:0] GEST_SWIPE_DOWN  = 3'd4;
    localparam logic [GEST_W-1:0] GEST_TAP         = 3'd5;

    // one poll of the touch controller
    typedef struct packed {
        logic              touch_present;
        logic [RAW_W-1:0]  raw_x;
        logic [RAW_W-1:0]  raw_y;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    // one result
    typedef struct packed {
        logic [PIX_X_W-1:0] pixel_x;
        logic [PIX_Y_W-1:0] pixel_y;
        logic               pressed;
        logic [GEST_W-1:0]  gesture;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic map;
        logic axis_y;
        logic div_step;
        logic store_x;
        logic store_y;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic touched;
        logic active;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/tcgd_ctrl.sv
// sequencing controller for the touch gesture detect core
`default_nettype none
`include "touch_calibrate_gesture_detect_core_macros.svh"

module tcgd_ctrl
    import tcgd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MAP_X,
        ST_DIV_X,
        ST_MAP_Y,
        ST_DIV_Y,
        ST_STORE_Y,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // command decode and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (status.touched) begin
                    state_next = ST_MAP_X;
                end else if (status.active) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAP_X: begin
                cmd.map    = 1'b1;
                state_next = ST_DIV_X;
            end
            ST_DIV_X: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_MAP_Y;
                end
            end
            ST_MAP_Y: begin
                cmd.store_x = 1'b1;
                cmd.map     = 1'b1;
                cmd.axis_y  = 1'b1;
                state_next  = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                cmd.div_step = 1'b1;
                cmd.axis_y   = 1'b1;
                if (status.div_last) begin
                    state_next = ST_STORE_Y;
                end
            end
            ST_STORE_Y: begin
                cmd.store_y = 1'b1;
                cmd.axis_y  = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                cmd.finish = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // checks
    `TCGD_ASSERT_NOW(a_finish_needs_room, aclk, aresetn, cmd.finish, status.out_free)
    `TCGD_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, cmd.load_in, !s_ready)
    `TCGD_ASSERT_NEXT(a_map_then_divide, aclk, aresetn, cmd.map, cmd.div_step)

endmodule

`default_nettype wire

// File: rtl/tcgd_datapath.sv
// calibration mapper, shared divider, gesture classifier and result register
`default_nettype none
`include "touch_calibrate_gesture_detect_core_macros.svh"

module tcgd_datapath
    import tcgd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                status
);

    localparam int MAX_SIZE = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int SW       = $clog2(MAX_SIZE + 1);
    localparam int PW       = RAW_W + SW;
    localparam int QW       = (SW > PIX_X_W) ? SW : PIX_X_W;
    localparam int CW       = $clog2(SW + 1);

    // configuration registers
    logic [RAW_W-1:0]     x_low_reg;
    logic [RAW_W-1:0]     x_high_reg;
    logic [RAW_W-1:0]     y_low_reg;
    logic [RAW_W-1:0]     y_high_reg;
    logic [THR_PIX_W-1:0] swipe_min_reg;
    logic [THR_PIX_W-1:0] tap_pix_reg;
    logic [THR_MS_W-1:0]  tap_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_low_reg     <= RST_RAW_LOW;
            x_high_reg    <= RST_RAW_HIGH;
            y_low_reg     <= RST_RAW_LOW;
            y_high_reg    <= RST_RAW_HIGH;
            swipe_min_reg <= RST_SWIPE_MIN;
            tap_pix_reg   <= RST_TAP_MAX_PIX;
            tap_ms_reg    <= RST_TAP_MAX_MS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RAW_X_LOW:   x_low_reg     <= cfg_wdata[RAW_W-1:0];
                REG_RAW_X_HIGH:  x_high_reg    <= cfg_wdata[RAW_W-1:0];
                REG_RAW_Y_LOW:   y_low_reg     <= cfg_wdata[RAW_W-1:0];
                REG_RAW_Y_HIGH:  y_high_reg    <= cfg_wdata[RAW_W-1:0];
                REG_SWIPE_MIN:   swipe_min_reg <= cfg_wdata[THR_PIX_W-1:0];
                REG_TAP_MAX_PIX: tap_pix_reg   <= cfg_wdata[THR_PIX_W-1:0];
                REG_TAP_MAX_MS:  tap_ms_reg    <= cfg_wdata[THR_MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input item capture
    in_item_t in_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
    end

    // clamp and scale the selected axis
    logic [RAW_W-1:0] raw_sel;
    logic [RAW_W-1:0] lo_sel;
    logic [RAW_W-1:0] hi_sel;
    logic [SW-1:0]    size_sel;
    logic [RAW_W-1:0] clamped;
    logic [RAW_W-1:0] offset;
    logic [PW-1:0]    product;

    always_comb begin
        raw_sel  = cmd.axis_y ? in_reg.raw_y : in_reg.raw_x;
        lo_sel   = cmd.axis_y ? y_low_reg : x_low_reg;
        hi_sel   = cmd.axis_y ? y_high_reg : x_high_reg;
        size_sel = cmd.axis_y ? SW'(SCREEN_HEIGHT) : SW'(SCREEN_WIDTH);
        if (raw_sel < lo_sel) begin
            clamped = lo_sel;
        end else if (raw_sel > hi_sel) begin
            clamped = hi_sel;
        end else begin
            clamped = raw_sel;
        end
        offset  = clamped - lo_sel;
        product = PW'(offset) * PW'(size_sel);
    end

    // restoring divider, one quotient bit a cycle; the quotient never
    // exceeds the screen size, so the top bits of the product start as
    // the partial remainder
    logic [RAW_W-1:0] rem_reg;
    logic [SW-1:0]    num_reg;
    logic [RAW_W-1:0] dvsr_reg;
    logic             empty_reg;
    logic [CW-1:0]    cnt_reg;
    logic [RAW_W:0]   trial;
    logic [RAW_W:0]   diff;
    logic             fits;
    logic [QW-1:0]    quo_ext;

    always_comb begin
        trial   = {rem_reg, num_reg[SW-1]};
        diff    = trial - {1'b0, dvsr_reg};
        fits    = (trial >= {1'b0, dvsr_reg});
        quo_ext = QW'(num_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.map) begin
            rem_reg   <= product[PW-1:SW];
            num_reg   <= product[SW-1:0];
            dvsr_reg  <= hi_sel - lo_sel;
            empty_reg <= (hi_sel <= lo_sel);
            cnt_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= fits ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
            num_reg <= {num_reg[SW-2:0], fits};
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // mapped point of the current poll
    logic [PIX_X_W-1:0] px_reg;
    logic [PIX_Y_W-1:0] py_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store_x) begin
            px_reg <= empty_reg ? '0 : quo_ext[PIX_X_W-1:0];
        end
        if (cmd.store_y) begin
            py_reg <= empty_reg ? '0 : quo_ext[PIX_Y_W-1:0];
        end
    end

    // touch tracking state
    logic               active_reg;
    logic [PIX_X_W-1:0] start_x_reg;
    logic [PIX_Y_W-1:0] start_y_reg;
    logic [TIME_W-1:0]  start_time_reg;
    logic [PIX_X_W-1:0] last_x_reg;
    logic [PIX_Y_W-1:0] last_y_reg;

    // release classification
    logic [PIX_X_W:0]   dx;
    logic [PIX_Y_W:0]   dy;
    logic [PIX_X_W-1:0] ax;
    logic [PIX_X_W-1:0] ay;
    logic [TIME_W-1:0]  duration;
    logic [GEST_W-1:0]  gesture;

    always_comb begin
        dx       = {1'b0, last_x_reg} - {1'b0, start_x_reg};
        dy       = {1'b0, last_y_reg} - {1'b0, start_y_reg};
        ax       = dx[PIX_X_W] ? PIX_X_W'((PIX_X_W+1)'(0) - dx) : dx[PIX_X_W-1:0];
        ay       = dy[PIX_Y_W] ? PIX_X_W'((PIX_Y_W+1)'(0) - dy) : PIX_X_W'(dy[PIX_Y_W-1:0]);
        duration = in_reg.now_ms - start_time_reg;
        if (ax > swipe_min_reg && ax > ay) begin
            gesture = dx[PIX_X_W] ? GEST_SWIPE_LEFT : GEST_SWIPE_RIGHT;
        end else if (ay > swipe_min_reg && ay > ax) begin
            gesture = dy[PIX_Y_W] ? GEST_SWIPE_UP : GEST_SWIPE_DOWN;
        end else if (duration < TIME_W'(tap_ms_reg) && ax < tap_pix_reg && ay < tap_pix_reg) begin
            gesture = GEST_TAP;
        end else begin
            gesture = GEST_NONE;
        end
    end

    // state update on result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (cmd.finish) begin
            active_reg <= in_reg.touch_present;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && in_reg.touch_present) begin
            if (!active_reg) begin
                start_x_reg    <= px_reg;
                start_y_reg    <= py_reg;
                start_time_reg <= in_reg.now_ms;
            end
            last_x_reg <= px_reg;
            last_y_reg <= py_reg;
        end
    end

    // result register
    logic      out_valid_reg;
    out_item_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (in_reg.touch_present) begin
                out_reg.pixel_x <= px_reg;
                out_reg.pixel_y <= py_reg;
                out_reg.pressed <= 1'b1;
                out_reg.gesture <= GEST_NONE;
            end else begin
                out_reg.pixel_x <= last_x_reg;
                out_reg.pixel_y <= last_y_reg;
                out_reg.pressed <= 1'b0;
                out_reg.gesture <= gesture;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // status to controller
    always_comb begin
        status.touched  = in_reg.touch_present;
        status.active   = active_reg;
        status.div_last = (cnt_reg == CW'(SW - 1));
        status.out_free = !out_valid_reg || m_ready;
    end

    // checks
    `TCGD_ASSERT_NOW(a_div_count_bound, aclk, aresetn, cmd.div_step, cnt_reg < CW'(SW))
    `TCGD_ASSERT_NEXT(a_press_sets_active, aclk, aresetn, cmd.finish && in_reg.touch_present, active_reg)
    `TCGD_ASSERT_NOW(a_release_clears_active, aclk, aresetn, out_valid_reg && !out_reg.pressed, !active_reg)

endmodule

`default_nettype wire

// File: rtl/touch_calibrate_gesture_detect_core.sv
// top level of the touch calibration and gesture detect core
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     in_item_t  (one touch poll)
//  m_        out        m_valid / m_ready     out_item_t (point, pressed, gesture)
//  cfg_      in         cfg_we                cfg_index, cfg_wdata
//
// a touched poll is mapped by the shared divider, which produces one quotient bit a cycle,
// for X and then for Y; its result is written to the result register after the Y store,
// and the core is ready for the next poll once the result is written.
// a release poll goes from dispatch straight to the result without mapping;
// an idle untouched poll returns to idle and gives no result.
// the result register holds a finished item while the next poll is being mapped;
// a stalled result channel holds the core only once the next result is ready.
// aresetn is synchronous, active low, and restores the default calibration.
`default_nettype none

module touch_calibrate_gesture_detect_core
    import tcgd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    tcgd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    tcgd_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: verif/tcgd_gesture_checker.sv
// checker that predicts and compares the results of the touch gesture detect core
module tcgd_gesture_checker
    import tcgd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output int                   fail_count,
    output int                   results_waiting,
    output int                   results_checked,
    output int                   releases_checked,
    output logic [7:0]           gestures_seen
);

    // calibration copy
    logic [RAW_W-1:0]     x_low, x_high, y_low, y_high;
    logic [THR_PIX_W-1:0] swipe_min;
    logic [THR_PIX_W-1:0] tap_pixels;
    logic [THR_MS_W-1:0]  tap_ms;

    // press tracking
    logic                 pressing;
    logic [PIX_X_W-1:0]   origin_x, latest_x;
    logic [PIX_Y_W-1:0]   origin_y, latest_y;
    logic [TIME_W-1:0]    origin_ms;

    // results still to come, oldest first
    out_item_t            expected_points[$];

    out_item_t            point, want, seen;
    in_item_t             poll;
    int                   failures  = 0;
    int                   checked   = 0;
    int                   releases  = 0;
    logic [7:0]           codes_hit = '0;

    // clamp one raw axis to its window and scale it onto 0..span pixels
    function automatic int unsigned map_raw(input logic [RAW_W-1:0] raw,
                                            input logic [RAW_W-1:0] lo,
                                            input logic [RAW_W-1:0] hi,
                                            input int unsigned span);
        int unsigned v;
        v = raw;
        if (hi <= lo) return 0;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return ((v - lo) * span) / (hi - lo);
    endfunction

    // gesture on lift, from the motion since the press and its duration
    function automatic logic [GEST_W-1:0] classify_release(input logic [TIME_W-1:0] now);
        int                dx, dy, ax, ay;
        logic [TIME_W-1:0] held_ms;
        dx      = int'(latest_x) - int'(origin_x);
        dy      = int'(latest_y) - int'(origin_y);
        ax      = (dx < 0) ? -dx : dx;
        ay      = (dy < 0) ? -dy : dy;
        held_ms = now - origin_ms;
        if (ax > int'(swipe_min) && ax > ay) return (dx > 0) ? GEST_SWIPE_RIGHT : GEST_SWIPE_LEFT;
        if (ay > int'(swipe_min) && ay > ax) return (dy > 0) ? GEST_SWIPE_DOWN : GEST_SWIPE_UP;
        if (held_ms < tap_ms && ax < int'(tap_pixels) && ay < int'(tap_pixels)) return GEST_TAP;
        return GEST_NONE;
    endfunction

    task automatic note_failure(input string what);
        if (failures < 10) $display("[%0t] %s", $time, what);
        failures++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            x_low      = RST_RAW_LOW;
            x_high     = RST_RAW_HIGH;
            y_low      = RST_RAW_LOW;
            y_high     = RST_RAW_HIGH;
            swipe_min  = RST_SWIPE_MIN;
            tap_pixels = RST_TAP_MAX_PIX;
            tap_ms     = RST_TAP_MAX_MS;
            pressing   = 1'b0;
            origin_x   = '0;
            origin_y   = '0;
            origin_ms  = '0;
            latest_x   = '0;
            latest_y   = '0;
            expected_points.delete();
        end else begin
            // register writes, unknown index ignored
            if (cfg_we) begin
                case (cfg_index)
                    REG_RAW_X_LOW:   x_low      = cfg_wdata[RAW_W-1:0];
                    REG_RAW_X_HIGH:  x_high     = cfg_wdata[RAW_W-1:0];
                    REG_RAW_Y_LOW:   y_low      = cfg_wdata[RAW_W-1:0];
                    REG_RAW_Y_HIGH:  y_high     = cfg_wdata[RAW_W-1:0];
                    REG_SWIPE_MIN:   swipe_min  = cfg_wdata[THR_PIX_W-1:0];
                    REG_TAP_MAX_PIX: tap_pixels = cfg_wdata[THR_PIX_W-1:0];
                    REG_TAP_MAX_MS:  tap_ms     = cfg_wdata[THR_MS_W-1:0];
                    default: ;
                endcase
            end

            // predict the result of each touched or release poll transfer
            if (s_valid && s_ready) begin
                poll = s_data;
                if (poll.touch_present) begin
                    point.pixel_x = PIX_X_W'(map_raw(poll.raw_x, x_low, x_high, SCREEN_WIDTH));
                    point.pixel_y = PIX_Y_W'(map_raw(poll.raw_y, y_low, y_high, SCREEN_HEIGHT));
                    point.pressed = 1'b1;
                    point.gesture = GEST_NONE;
                    if (!pressing) begin
                        pressing  = 1'b1;
                        origin_x  = point.pixel_x;
                        origin_y  = point.pixel_y;
                        origin_ms = poll.now_ms;
                    end
                    latest_x = point.pixel_x;
                    latest_y = point.pixel_y;
                    expected_points.push_back(point);
                end else if (pressing) begin
                    point.pixel_x = latest_x;
                    point.pixel_y = latest_y;
                    point.pressed = 1'b0;
                    point.gesture = classify_release(poll.now_ms);
                    pressing      = 1'b0;
                    expected_points.push_back(point);
                end
            end

            // compare each result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                seen = m_data;
                if (expected_points.size() == 0) begin
                    note_failure($sformatf("unexpected result x=%0d y=%0d pressed=%0d gesture=%0d",
                                           seen.pixel_x, seen.pixel_y, seen.pressed, seen.gesture));
                end else begin
                    want = expected_points.pop_front();
                    if (seen.pixel_x !== want.pixel_x || seen.pixel_y !== want.pixel_y ||
                        seen.pressed !== want.pressed || seen.gesture !== want.gesture) begin
                        note_failure($sformatf(
                            "result %0d: expected x=%0d y=%0d pressed=%0d gesture=%0d, got x=%0d y=%0d pressed=%0d gesture=%0d",
                            checked, want.pixel_x, want.pixel_y, want.pressed, want.gesture,
                            seen.pixel_x, seen.pixel_y, seen.pressed, seen.gesture));
                    end
                    checked++;
                    if (!want.pressed) releases++;
                    codes_hit[want.gesture] = 1'b1;
                end
            end
        end

        fail_count       <= failures;
        results_waiting  <= expected_points.size();
        results_checked  <= checked;
        releases_checked <= releases;
        gestures_seen    <= codes_hit;
    end

endmodule

// File: verif/testbench.sv
// top of the touch gesture detect testbench: clock, reset, polls, calibration and verdict
module testbench;
    import tcgd_pkg::*;

    localparam int                   HALF_PERIOD   = 10;
    localparam int                   RESET_CYCLES  = 8;
    localparam int                   SETTLE_CYCLES = 40;
    localparam int                   STALL_LIMIT   = 5000;
    localparam int                   PHASES        = 8;
    localparam int                   PHASE_POLLS   = 148;
    localparam int                   IDLE_PERCENT  = 27;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    bit                   steady       = 1'b0;
    bit                   touching     = 1'b0;
    int                   polls_sent   = 0;
    int                   stall_cycles = 0;
    logic [TIME_W-1:0]    clock_ms;

    int                   fail_count;
    int                   results_waiting;
    int                   results_checked;
    int                   releases_checked;
    logic [7:0]           gestures_seen;

    always #HALF_PERIOD aclk = ~aclk;

    touch_calibrate_gesture_detect_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tcgd_gesture_checker gesture_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .results_waiting  (results_waiting),
        .results_checked  (results_checked),
        .releases_checked (releases_checked),
        .gestures_seen    (gestures_seen)
    );

    // result side stalls at random outside the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one poll, with random gaps first, and hold it until the transfer
    task automatic offer_poll(input in_item_t poll);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= poll;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
    endtask

    // stop sending, wait for every expected result, then let the core settle
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_waiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write, random bits above the register width
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int width);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DAT_W'(($urandom << width) | value);
        @(posedge aclk);
    endtask

    // new calibration while the core is idle
    task automatic load_calibration(input int unsigned xl, xh, yl, yh, swipe, tap_pix, tap_max);
        drain_results();
        write_reg(REG_RAW_X_LOW, xl, RAW_W);
        write_reg(REG_RAW_X_HIGH, xh, RAW_W);
        write_reg(REG_RAW_Y_LOW, yl, RAW_W);
        write_reg(REG_RAW_Y_HIGH, yh, RAW_W);
        write_reg(REG_SWIPE_MIN, swipe, THR_PIX_W);
        write_reg(REG_TAP_MAX_PIX, tap_pix, THR_PIX_W);
        write_reg(REG_TAP_MAX_MS, tap_max, THR_MS_W);
        // unknown index last, so a stray decode would corrupt a live register
        write_reg(REG_UNUSED, $urandom_range(16'hFFFF), CFG_DAT_W);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // calibration window for one axis: mostly ordered, sometimes empty or arbitrary
    function automatic logic [2*RAW_W-1:0] pick_window();
        int unsigned lo, hi, pick;
        pick = $urandom_range(99);
        lo   = $urandom_range(4095);
        if (pick < 70) hi = lo + $urandom_range(4095 - lo);
        else if (pick < 85) hi = $urandom_range(lo);
        else hi = $urandom_range(4095);
        return {RAW_W'(lo), RAW_W'(hi)};
    endfunction

    function automatic int clip_raw(input int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // untouched poll while nothing is pressed
    task automatic idle_poll();
        in_item_t poll;
        poll.touch_present = 1'b0;
        poll.raw_x         = RAW_W'($urandom);
        poll.raw_y         = RAW_W'($urandom);
        poll.now_ms        = clock_ms;
        offer_poll(poll);
        clock_ms = clock_ms + TIME_W'($urandom_range(1, 50));
    endtask

    // one press: n touched polls moving from start to end, then the lift unless cut short
    task automatic press_and_release(input int sx, sy, ex, ey, n,
                                     input logic [TIME_W-1:0] t0, hold, input bit lift);
        in_item_t poll;
        int       k;
        for (k = 0; k < n; k++) begin
            poll.touch_present = 1'b1;
            poll.raw_x         = RAW_W'(sx + (ex - sx) * k / ((n > 1) ? n - 1 : 1));
            poll.raw_y         = RAW_W'(sy + (ey - sy) * k / ((n > 1) ? n - 1 : 1));
            poll.now_ms        = t0 + TIME_W'(longint'(hold) * k / n);
            offer_poll(poll);
            polls_sent++;
        end
        if (lift) begin
            poll.touch_present = 1'b0;
            poll.raw_x         = RAW_W'($urandom);
            poll.raw_y         = RAW_W'($urandom);
            poll.now_ms        = t0 + hold;
            offer_poll(poll);
            polls_sent++;
        end
        touching = !lift;
        clock_ms = t0 + hold + TIME_W'($urandom_range(1, 3000));
    endtask

    // random press shaped toward taps, swipes, long holds and wild drags
    task automatic random_gesture();
        int                sx, sy, ex, ey, n, kind, jitter;
        logic [TIME_W-1:0] hold;
        kind   = $urandom_range(99);
        sx     = $urandom_range(4095);
        sy     = $urandom_range(4095);
        ex     = $urandom_range(4095);
        ey     = $urandom_range(4095);
        n      = $urandom_range(1, 6);
        jitter = $urandom_range(0, 160);
        hold   = TIME_W'($urandom_range(0, 1500));
        if (kind < 30) begin
            // small motion, short press
            ex   = clip_raw(sx + jitter - 80);
            ey   = clip_raw(sy + int'($urandom_range(0, 160)) - 80);
            hold = TIME_W'($urandom_range(0, 700));
        end else if (kind < 50) begin
            // one axis dominant
            if ($urandom_range(1)) ey = clip_raw(sy + jitter - 80);
            else ex = clip_raw(sx + jitter - 80);
        end else if (kind < 60) begin
            // held in place for any duration
            ex   = sx;
            ey   = sy;
            n    = $urandom_range(1, 3);
            hold = $urandom;
        end else if (kind < 65) begin
            n = $urandom_range(7, 16);
        end
        // push the timestamp near its wrap now and then
        if ($urandom_range(99) < 5) clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 2000));
        press_and_release(sx, sy, ex, ey, n, clock_ms, hold, $urandom_range(99) >= 8);
    endtask

    initial begin
        int                 phase, target;
        logic [2*RAW_W-1:0] xw, yw;
        clock_ms = $urandom;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed presses on the reset calibration
        idle_poll();
        // clamped corners, swipe right
        press_and_release(0, 0, 4095, 4095, 2, 32'd1000, 32'd200, 1'b1);
        // tap just inside and just outside the time limit
        press_and_release(2050, 2050, 2050, 2050, 1, 32'd5000, 32'd449, 1'b1);
        press_and_release(2050, 2050, 2050, 2050, 1, 32'd6000, 32'd450, 1'b1);
        // swipe left, up and down
        press_and_release(3500, 2000, 1000, 2100, 3, 32'd7000, 32'd300, 1'b1);
        press_and_release(2000, 3500, 2000, 500, 2, 32'd8000, 32'd250, 1'b1);
        press_and_release(2000, 500, 2050, 3500, 2, 32'd9000, 32'd250, 1'b1);
        // equal motion on both axes, no gesture
        press_and_release(300, 300, 1394, 1759, 2, 32'd10000, 32'd100, 1'b1);
        // top of both windows, tap across the timestamp wrap
        press_and_release(3800, 3800, 3800, 3800, 1, 32'hFFFF_FFF0, 32'h20, 1'b1);

        // random presses over a series of calibrations
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_calibration(0, 4095, 0, 4095, 0, 320, 65535);
                1: load_calibration(4095, 0, 2048, 2048, 320, 0, 0);
                2: load_calibration(1000, 1001, 4094, 4095, 1, 1, 1);
                default: begin
                    xw = pick_window();
                    yw = pick_window();
                    load_calibration(xw[2*RAW_W-1:RAW_W], xw[RAW_W-1:0],
                                     yw[2*RAW_W-1:RAW_W], yw[RAW_W-1:0],
                                     $urandom_range(0, 320), $urandom_range(0, 320),
                                     $urandom_range(0, 65535));
                end
            endcase
            steady = (phase == 2);
            target = polls_sent + PHASE_POLLS;
            while (polls_sent < target) begin
                if (!touching && $urandom_range(3) == 0) idle_poll();
                random_gesture();
            end
        end
        steady = 1'b0;
        drain_results();

        $display("covered %0d polls: directed presses, then %0d calibrations incl. empty windows",
                 polls_sent, PHASES);
        $display("%0d results checked, %0d releases, gesture codes seen (bit per code) %b",
                 results_checked, releases_checked, gestures_seen);
        if (fail_count == 0 && results_waiting == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, results_waiting);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcgd_pkg.sv
rtl/tcgd_ctrl.sv
rtl/tcgd_datapath.sv
rtl/touch_calibrate_gesture_detect_core.sv
verif/tcgd_gesture_checker.sv
verif/testbench.sv
